[sv/rjb_pkg.sv]
// Shared constants, codes and types of the RTP jitter buffer.
`timescale 1ns / 1ps
package rjb_pkg;

  // Geometry: slot and history depths are powers of two
  localparam int SLOT_AW      = 6;
  localparam int SLOTS        = 1 << SLOT_AW;
  localparam int HIST_AW      = 6;
  localparam int HISTORY      = 1 << HIST_AW;
  localparam int SHORT_WINDOW = 16;
  localparam int MIN_DEPTH    = 1;
  localparam int MAX_DEPTH    = 32;

  localparam int DEPTH_W = 7;
  localparam int HELD_W  = SLOT_AW + 1;
  localparam int CNT_W   = HIST_AW + 1;
  localparam int DIFF_W  = 31;
  localparam int CFG_IW  = 8;
  localparam int CFG_DW  = 16;

  // Operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PULL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_PULL_OK   = 3'd0;
  localparam logic [2:0] ST_PULL_MISS = 3'd1;
  localparam logic [2:0] ST_STORED    = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_TICK_DONE = 3'd4;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_FRAME_SIZE  = 8'd0;
  localparam logic [CFG_IW-1:0] REG_USE_PREFETCH = 8'd1;
  localparam logic [CFG_IW-1:0] REG_INIT_PREFETCH = 8'd2;
  localparam logic [CFG_IW-1:0] REG_ACCEPTED_PT = 8'd3;

  localparam logic [15:0]        RST_FRAME_SIZE = 16'd160;
  localparam logic [DEPTH_W-1:0] RST_DEPTH      = 7'd3;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] ts;
    logic [15:0] handle;
  } slot_t;

  typedef struct packed {
    logic              start;
    logic              log_en;
    logic [DIFF_W-1:0] log_data;
  } dep_ctl_t;

  typedef struct packed {
    logic               done;
    logic               has_diffs;
    logic [DEPTH_W-1:0] depth;
  } dep_sts_t;

endpackage

[sv/rjb_ifs.sv]
// Handshake channel interfaces of the jitter buffer.
`timescale 1ns / 1ps
interface rjb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] seq;
  logic [31:0] timestamp;
  logic [31:0] ssrc;
  logic [6:0]  payload_type;
  logic [15:0] handle;
  modport source (output valid, op, seq, timestamp, ssrc, payload_type, handle, input ready);
  modport sink (input valid, op, seq, timestamp, ssrc, payload_type, handle, output ready);
endinterface

interface rjb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_handle;
  logic [15:0] out_seq;
  logic [31:0] out_timestamp;
  logic [6:0]  fill_level;
  logic        prefetching;
  modport source (output valid, status, out_handle, out_seq, out_timestamp, fill_level,
                  prefetching, input ready);
  modport sink (input valid, status, out_handle, out_seq, out_timestamp, fill_level,
                prefetching, output ready);
endinterface

interface rjb_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/rjb_slot_ram.sv]
// Slot store: sequence, timestamp and handle per slot, registered read.
`timescale 1ns / 1ps
module rjb_slot_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rjb_pkg::SLOT_AW-1:0] waddr,
  input  rjb_pkg::slot_t            wdata,
  input  logic [rjb_pkg::SLOT_AW-1:0] raddr,
  output rjb_pkg::slot_t            rdata
);

  rjb_pkg::slot_t mem [rjb_pkg::SLOTS];

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rjb_depth.sv]
// Arrival history and Chebyshev depth estimator over two windows.
`timescale 1ns / 1ps
module rjb_depth (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        frame_size,
  input  rjb_pkg::dep_ctl_t  ctl,
  output rjb_pkg::dep_sts_t  sts
);

  localparam int HA     = rjb_pkg::HIST_AW;
  localparam int CW     = rjb_pkg::CNT_W;
  localparam int DW     = rjb_pkg::DIFF_W;
  localparam int EW     = rjb_pkg::DEPTH_W;
  localparam int SUM_W  = DW + HA;
  localparam int DIV_CW = $clog2(SUM_W + 1);
  localparam int SPAN_W = EW + 16;
  localparam int SQ_W   = 2 * SPAN_W;
  localparam int N9_W   = CW + 4;
  localparam int LHS_W  = SQ_W + N9_W;
  localparam int Q100_W = 64 + 7;
  localparam int SHORT_N = (rjb_pkg::SHORT_WINDOW < rjb_pkg::HISTORY) ?
                           rjb_pkg::SHORT_WINDOW : rjb_pkg::HISTORY;

  localparam logic [3:0] D_IDLE = 4'd0, D_INIT = 4'd1, D_S_RD = 4'd2, D_S_ACC = 4'd3,
                         D_DIV = 4'd4, D_Q_RD = 4'd5, D_Q_ABS = 4'd6, D_Q_SQ = 4'd7,
                         D_Q_ACC = 4'd8, D_E_INIT = 4'd9, D_E_M1 = 4'd10, D_E_M2 = 4'd11,
                         D_E_M3 = 4'd12, D_E_CMP = 4'd13, D_NEXT = 4'd14;

  logic [DW-1:0] mem [rjb_pkg::HISTORY];
  logic [DW-1:0] rdata;
  logic [HA-1:0] wr_idx, rd_idx, st_idx;
  logic [CW-1:0] count, n, k;
  logic [3:0]    state;
  logic          win;
  logic [SUM_W-1:0]  sum, num, quo;
  logic [CW-1:0]     rem;
  logic [CW:0]       rem_sh;
  logic              rem_ge;
  logic [DIV_CW-1:0] div_cnt;
  logic [DW-1:0]     mean, absd;
  logic [2*DW-1:0]   sq;
  logic [63:0]       q;
  logic              q_ovf;
  logic [64:0]       q_sum;
  logic [Q100_W-1:0] q100;
  logic [EW-1:0]     e, cand, best;
  logic [SPAN_W-1:0] span;
  logic [SQ_W-1:0]   span2;
  logic [LHS_W-1:0]  lhs;
  logic [N9_W-1:0]   n9;
  logic [CW-1:0]     n_next;
  logic              done;

  // history memory: log writes, registered read
  always_ff @(posedge clk) begin
    if (ctl.log_en) begin
      mem[wr_idx] <= ctl.log_data;
    end
    rdata <= mem[rd_idx];
  end

  // divider step
  assign rem_sh = {rem, num[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, n};
  assign mean   = quo[DW-1:0];
  assign q_sum  = {1'b0, q} + {{(65 - 2 * DW){1'b0}}, sq};
  assign n9     = {n, 3'b000} + {4'b0000, n};
  assign n_next = win ? count : ((count < CW'(SHORT_N)) ? count : CW'(SHORT_N));

  assign sts.done      = done;
  assign sts.has_diffs = count != '0;
  assign sts.depth     = best;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state  <= D_IDLE;
      wr_idx <= '0;
      count  <= '0;
      best   <= '0;
    end else begin
      // arrival logging
      if (ctl.log_en) begin
        wr_idx <= wr_idx + 1'b1;
        if (count != CW'(rjb_pkg::HISTORY)) begin
          count <= count + 1'b1;
        end
      end
      case (state)
        D_IDLE: begin
          if (ctl.start) begin
            win   <= 1'b0;
            best  <= '0;
            state <= D_INIT;
          end
        end
        // window setup
        D_INIT: begin
          n      <= n_next;
          st_idx <= wr_idx - n_next[HA-1:0];
          rd_idx <= wr_idx - n_next[HA-1:0];
          sum    <= '0;
          k      <= '0;
          state  <= D_S_RD;
        end
        D_S_RD: state <= D_S_ACC;
        D_S_ACC: begin
          sum    <= sum + {{HA{1'b0}}, rdata};
          rd_idx <= rd_idx + 1'b1;
          k      <= k + 1'b1;
          if (k == n - 1'b1) begin
            num     <= sum + {{HA{1'b0}}, rdata};
            rem     <= '0;
            quo     <= '0;
            div_cnt <= '0;
            state   <= D_DIV;
          end else begin
            state <= D_S_RD;
          end
        end
        // restoring division, one quotient bit a cycle
        D_DIV: begin
          rem     <= rem_ge ? CW'(rem_sh - {1'b0, n}) : rem_sh[CW-1:0];
          quo     <= {quo[SUM_W-2:0], rem_ge};
          num     <= {num[SUM_W-2:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CW'(SUM_W - 1)) begin
            rd_idx <= st_idx;
            k      <= '0;
            q      <= '0;
            q_ovf  <= 1'b0;
            state  <= D_Q_RD;
          end
        end
        // sum of squared deviations
        D_Q_RD: state <= D_Q_ABS;
        D_Q_ABS: begin
          absd  <= (rdata >= mean) ? rdata - mean : mean - rdata;
          state <= D_Q_SQ;
        end
        D_Q_SQ: begin
          sq    <= absd * absd;
          state <= D_Q_ACC;
        end
        D_Q_ACC: begin
          q      <= q_sum[63:0];
          q_ovf  <= q_ovf | q_sum[64];
          rd_idx <= rd_idx + 1'b1;
          k      <= k + 1'b1;
          state  <= (k == n - 1'b1) ? D_E_INIT : D_Q_RD;
        end
        // least depth meeting the bound
        D_E_INIT: begin
          q100 <= {q, 6'b0} + {1'b0, q, 5'b0} + {4'b0, q, 2'b0};
          e    <= EW'(rjb_pkg::MIN_DEPTH);
          if (rjb_pkg::MIN_DEPTH >= rjb_pkg::MAX_DEPTH) begin
            cand  <= EW'(rjb_pkg::MAX_DEPTH);
            state <= D_NEXT;
          end else begin
            state <= D_E_M1;
          end
        end
        D_E_M1: begin
          span  <= e * frame_size;
          state <= D_E_M2;
        end
        D_E_M2: begin
          span2 <= span * span;
          state <= D_E_M3;
        end
        D_E_M3: begin
          lhs   <= span2 * n9;
          state <= D_E_CMP;
        end
        D_E_CMP: begin
          if (!q_ovf && ({{(Q100_W - LHS_W){1'b0}}, lhs} >= q100)) begin
            cand  <= e;
            state <= D_NEXT;
          end else if (e == EW'(rjb_pkg::MAX_DEPTH - 1)) begin
            cand  <= EW'(rjb_pkg::MAX_DEPTH);
            state <= D_NEXT;
          end else begin
            e     <= e + 1'b1;
            state <= D_E_M1;
          end
        end
        D_NEXT: begin
          if (cand > best) begin
            best <= cand;
          end
          if (!win) begin
            win   <= 1'b1;
            state <= D_INIT;
          end else begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[sv/rtp_jitter_buffer_top.sv]
// Top level of the adaptive RTP jitter buffer: control sequencer and state.
// A pull scans the slots in order, each through the registered read of the slot
// memory; an underflow adds a run of the depth estimate over both windows.
// One operation at a time; the next is taken once the sequencer is idle.
// Synchronous reset clears all slot valid bits at once; no clearing pass.
`timescale 1ns / 1ps
module rtp_jitter_buffer_top (
  input logic        clk,
  input logic        rst,
  rjb_in_if.sink     pkt_in,
  rjb_out_if.source  res_out,
  rjb_cfg_if.sink    cfg
);

  localparam int AW = rjb_pkg::SLOT_AW;
  localparam int HW = rjb_pkg::HELD_W;
  localparam int EW = rjb_pkg::DEPTH_W;

  localparam logic [3:0] S_IDLE = 4'd0, S_PUSH0 = 4'd1, S_PUSH1 = 4'd2, S_PUSH2 = 4'd3,
                         S_PULL0 = 4'd4, S_SCAN_RD = 4'd5, S_SCAN_EV = 4'd6,
                         S_TAKE_RD = 4'd7, S_TAKE_EV = 4'd8, S_DEPTH = 4'd9,
                         S_TICK = 4'd10, S_FIN = 4'd11;

  logic [3:0] state;

  // configuration
  logic [15:0]   frame_size;
  logic          use_prefetch;
  logic [6:0]    accepted_pt;

  // buffer state
  logic [rjb_pkg::SLOTS-1:0] slot_valid;
  logic [HW-1:0] held;
  logic [AW-1:0] last_pulled;
  logic [15:0]   last_played;
  logic [31:0]   expected_ts, local_clock, stream_source;
  logic          in_prefetch, awaiting_first;
  logic [EW-1:0] prefetch_depth;

  // latched transaction and scan control
  logic [15:0] p_seq, p_handle;
  logic [31:0] p_ts, p_ssrc;
  logic [6:0]  p_pt;
  logic [AW-1:0] mem_addr, scan_cnt, second;
  logic          have_second;
  logic [2:0]    r_status;
  logic [15:0]   r_handle, r_seq;
  logic [31:0]   r_ts;

  // result register
  logic        res_valid;
  logic [2:0]  o_status;
  logic [15:0] o_handle, o_seq;
  logic [31:0] o_ts;
  logic [6:0]  o_fill;
  logic        o_pref;

  rjb_pkg::slot_t    rd, wdata;
  logic              we;
  rjb_pkg::dep_ctl_t dep_ctl;
  rjb_pkg::dep_sts_t dep_sts;
  logic              dep_start;

  logic [AW-1:0] idx;
  logic [15:0]   seq_d, stale_d, half;
  logic          newer, stale, in_win, fresh, pos_valid;
  logic [31:0]   dh, dl, ad, mag;
  logic [HW-1:0] held_inc, held_dec;

  rjb_slot_ram u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (mem_addr),
    .rdata (rd)
  );

  rjb_depth u_depth (
    .clk        (clk),
    .rst        (rst),
    .frame_size (frame_size),
    .ctl        (dep_ctl),
    .sts        (dep_sts)
  );

  // datapath helpers
  assign idx       = p_seq[AW-1:0];
  assign seq_d     = p_seq - rd.seq;
  assign newer     = (seq_d != 16'd0) && !seq_d[15];
  assign stale_d   = rd.seq - last_played;
  assign stale     = stale_d[15];
  assign half      = {1'b0, frame_size[15:1]};
  assign dh        = rd.ts - (expected_ts + {16'd0, half});
  assign dl        = rd.ts - (expected_ts - {16'd0, half});
  assign in_win    = (dh != 32'd0) && dh[31] && (dl != 32'd0) && !dl[31];
  assign pos_valid = slot_valid[mem_addr];
  assign fresh     = pos_valid && !stale;
  assign held_inc  = held + 1'b1;
  assign held_dec  = (held != '0) ? held - 1'b1 : held;
  assign ad        = p_ts - local_clock;
  assign mag       = ad[31] ? 32'd0 - ad : ad;

  assign wdata.seq    = p_seq;
  assign wdata.ts     = p_ts;
  assign wdata.handle = p_handle;
  assign we = (state == S_PUSH1) && (!slot_valid[idx] || newer);

  assign dep_ctl.start    = dep_start;
  assign dep_ctl.log_en   = state == S_PUSH2;
  assign dep_ctl.log_data = mag[31] ? {rjb_pkg::DIFF_W{1'b1}} : mag[rjb_pkg::DIFF_W-1:0];

  // channel handshakes
  assign pkt_in.ready          = state == S_IDLE;
  assign cfg.ready             = 1'b1;
  assign res_out.valid         = res_valid;
  assign res_out.status        = o_status;
  assign res_out.out_handle    = o_handle;
  assign res_out.out_seq       = o_seq;
  assign res_out.out_timestamp = o_ts;
  assign res_out.fill_level    = o_fill;
  assign res_out.prefetching   = o_pref;

  // sequencer and state update
  always_ff @(posedge clk) begin
    dep_start <= 1'b0;
    if (rst) begin
      state          <= S_IDLE;
      frame_size     <= rjb_pkg::RST_FRAME_SIZE;
      use_prefetch   <= 1'b1;
      accepted_pt    <= '0;
      slot_valid     <= '0;
      held           <= '0;
      last_pulled    <= '0;
      last_played    <= '0;
      expected_ts    <= '0;
      local_clock    <= '0;
      stream_source  <= '0;
      in_prefetch    <= 1'b1;
      awaiting_first <= 1'b1;
      prefetch_depth <= rjb_pkg::RST_DEPTH;
      res_valid      <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        case (cfg.index)
          rjb_pkg::REG_FRAME_SIZE:   frame_size <= cfg.data;
          rjb_pkg::REG_USE_PREFETCH: use_prefetch <= cfg.data[0];
          rjb_pkg::REG_INIT_PREFETCH: begin
            prefetch_depth <= (cfg.data[EW-1:0] < EW'(rjb_pkg::MIN_DEPTH)) ?
                              EW'(rjb_pkg::MIN_DEPTH) : cfg.data[EW-1:0];
          end
          rjb_pkg::REG_ACCEPTED_PT:  accepted_pt <= cfg.data[6:0];
          default: ;
        endcase
      end

      if (res_valid && res_out.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (pkt_in.valid) begin
            p_seq    <= pkt_in.seq;
            p_ts     <= pkt_in.timestamp;
            p_ssrc   <= pkt_in.ssrc;
            p_pt     <= pkt_in.payload_type;
            p_handle <= pkt_in.handle;
            mem_addr <= pkt_in.seq[AW-1:0];
            r_handle <= '0;
            r_seq    <= '0;
            r_ts     <= '0;
            case (pkt_in.op)
              rjb_pkg::OP_PUSH: state <= S_PUSH0;
              rjb_pkg::OP_PULL: state <= S_PULL0;
              rjb_pkg::OP_TICK: state <= S_TICK;
              default:          state <= S_IDLE;
            endcase
          end
        end

        // payload type check and source change; slot read in flight
        S_PUSH0: begin
          if (p_pt != accepted_pt) begin
            r_status <= rjb_pkg::ST_DROPPED;
            state    <= S_FIN;
          end else begin
            if (awaiting_first) begin
              awaiting_first <= 1'b0;
            end else if (stream_source != p_ssrc) begin
              slot_valid  <= '0;
              held        <= '0;
              last_pulled <= '0;
              expected_ts <= '0;
              local_clock <= '0;
              in_prefetch <= 1'b1;
            end
            if (!use_prefetch && (awaiting_first || stream_source != p_ssrc)) begin
              stream_source <= p_ssrc;
              last_pulled   <= idx - 1'b1;
              last_played   <= p_seq - 16'd1;
              expected_ts   <= p_ts - {16'd0, frame_size};
              local_clock   <= p_ts;
            end
            state <= S_PUSH1;
          end
        end

        // store or collide
        S_PUSH1: begin
          r_status <= rjb_pkg::ST_STORED;
          state    <= use_prefetch ? S_PUSH2 : S_FIN;
          if (slot_valid[idx]) begin
            if (!newer) begin
              r_status <= rjb_pkg::ST_DROPPED;
              state    <= S_FIN;
            end
          end else begin
            slot_valid[idx] <= 1'b1;
            held            <= held_inc;
            if (use_prefetch && in_prefetch) begin
              if (held_inc == HW'(1)) begin
                stream_source <= p_ssrc;
                last_pulled   <= idx - 1'b1;
                last_played   <= p_seq - 16'd1;
                expected_ts   <= p_ts - {16'd0, frame_size};
                local_clock   <= p_ts;
              end else if (held_inc >= prefetch_depth) begin
                in_prefetch <= 1'b0;
              end
            end
          end
        end

        // arrival logged by the depth unit this cycle
        S_PUSH2: state <= S_FIN;

        S_PULL0: begin
          r_status <= rjb_pkg::ST_PULL_MISS;
          if (use_prefetch && in_prefetch) begin
            state <= S_FIN;
          end else if (held == '0) begin
            in_prefetch <= 1'b1;
            if (dep_sts.has_diffs) begin
              dep_start <= 1'b1;
              state     <= S_DEPTH;
            end else begin
              state <= S_FIN;
            end
          end else begin
            mem_addr    <= last_pulled + 1'b1;
            scan_cnt    <= '0;
            have_second <= 1'b0;
            state       <= S_SCAN_RD;
          end
        end

        S_SCAN_RD: state <= S_SCAN_EV;

        // examine one slot
        S_SCAN_EV: begin
          if (pos_valid && stale) begin
            slot_valid[mem_addr] <= 1'b0;
            held                 <= held_dec;
          end
          if (fresh && !have_second) begin
            have_second <= 1'b1;
            second      <= mem_addr;
          end
          if (fresh && in_win) begin
            r_status             <= rjb_pkg::ST_PULL_OK;
            r_handle             <= rd.handle;
            r_seq                <= rd.seq;
            r_ts                 <= rd.ts;
            last_played          <= rd.seq;
            last_pulled          <= mem_addr;
            expected_ts          <= rd.ts;
            slot_valid[mem_addr] <= 1'b0;
            held                 <= held_dec;
            state                <= S_FIN;
          end else if (scan_cnt == {AW{1'b1}}) begin
            if (have_second) begin
              mem_addr <= second;
              state    <= S_TAKE_RD;
            end else if (fresh) begin
              state <= S_TAKE_RD;
            end else begin
              r_status    <= rjb_pkg::ST_PULL_MISS;
              in_prefetch <= 1'b1;
              if (dep_sts.has_diffs) begin
                dep_start <= 1'b1;
                state     <= S_DEPTH;
              end else begin
                state <= S_FIN;
              end
            end
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
            mem_addr <= mem_addr + 1'b1;
            state    <= S_SCAN_RD;
          end
        end

        S_TAKE_RD: state <= S_TAKE_EV;

        // take the first fresh packet of the scan
        S_TAKE_EV: begin
          r_status             <= rjb_pkg::ST_PULL_OK;
          r_handle             <= rd.handle;
          r_seq                <= rd.seq;
          r_ts                 <= rd.ts;
          last_played          <= rd.seq;
          last_pulled          <= mem_addr;
          expected_ts          <= rd.ts;
          slot_valid[mem_addr] <= 1'b0;
          held                 <= held_dec;
          state                <= S_FIN;
        end

        S_DEPTH: begin
          if (dep_sts.done) begin
            prefetch_depth <= dep_sts.depth;
            state          <= S_FIN;
          end
        end

        S_TICK: begin
          if (!in_prefetch || !use_prefetch) begin
            expected_ts <= expected_ts + {16'd0, frame_size};
          end
          local_clock <= local_clock + {16'd0, frame_size};
          r_status    <= rjb_pkg::ST_TICK_DONE;
          state       <= S_FIN;
        end

        // load the result register once it is free
        S_FIN: begin
          if (!res_valid || res_out.ready) begin
            res_valid <= 1'b1;
            o_status  <= r_status;
            o_handle  <= r_handle;
            o_seq     <= r_seq;
            o_ts      <= r_ts;
            o_fill    <= 7'(held);
            o_pref    <= in_prefetch;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
